/* hdl/flc_pkg.sv */
// Package for the fully associative LRU cache.
// Holds the controller state type; no dependencies.
package flc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINAL,
    ST_DONE
  } flc_state_t;

endpackage

/* hdl/flc_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module flc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fully_associative_lru_cache.sv */
// Fully associative cache with LRU replacement: tag memory, recency-list memory
// and the controller that scans and reorders them. Uses flc_pkg and flc_ram.
// A fill scans every filled entry; a hit scans up to the hit and moves the later list
// entries down; a replacement scans every entry and moves the list. Both walk the single
// read port of the recency memory. A new item is taken while the last result still waits.
// Synchronous reset empties the cache (fill count 0); memories are not cleared.
module fully_associative_lru_cache #(
  parameter int ENTRIES      = 128,
  parameter int OFFSET_BITS  = 2,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [ADDRESS_BITS-1:0]             address,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                hit,
  output logic [ADDRESS_BITS-OFFSET_BITS-1:0] tag,
  output logic [$clog2(ENTRIES)-1:0]          slot
);

  import flc_pkg::*;

  localparam int TAG_W  = ADDRESS_BITS - OFFSET_BITS;
  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  flc_state_t state, state_next;

  logic [TAG_W-1:0]  tag_q;
  logic              hit_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] lru;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  logic              a_vld;
  logic [CNT_W-1:0]  a_pos;
  logic              b_vld;
  logic [CNT_W-1:0]  b_pos;
  logic [SLOT_W-1:0] b_slot;

  logic              tag_we;
  logic [SLOT_W-1:0] tag_waddr;
  logic [TAG_W-1:0]  tag_rdata;
  logic              rec_we;
  logic [SLOT_W-1:0] rec_waddr;
  logic [SLOT_W-1:0] rec_wdata;
  logic [SLOT_W-1:0] rec_rdata;
  logic [CNT_W-1:0]  last_pos;

  logic full, issue, scan_hit, scan_end;

  assign full      = (count == CNT_W'(ENTRIES));
  assign issue     = (pos < count);
  assign scan_hit  = b_vld && (tag_rdata == tag_q);
  assign scan_end  = !issue && !a_vld && !b_vld;
  assign req_stall = (state != ST_IDLE);
  assign last_pos  = (hit_q || full) ? (count - CNT_W'(1)) : count;

  flc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_mem (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_q),
    .raddr (rec_rdata),
    .rdata (tag_rdata)
  );

  flc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_rec_mem (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (pos[SLOT_W-1:0]),
    .rdata (rec_rdata)
  );

  always_comb begin
    state_next = state;
    tag_we     = 1'b0;
    tag_waddr  = slot_q;
    rec_we     = 1'b0;
    rec_waddr  = SLOT_W'(a_pos - CNT_W'(1));
    rec_wdata  = rec_rdata;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || (scan_end && full)) state_next = ST_SHIFT;
        else if (scan_end) state_next = ST_FINAL;
      end
      ST_SHIFT: begin
        // move each later list entry down one position
        rec_we = a_vld;
        if (!issue && !a_vld) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        rec_we    = 1'b1;
        rec_waddr = last_pos[SLOT_W-1:0];
        rec_wdata = slot_q;
        tag_we    = !hit_q;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      count     <= '0;
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != ST_DONE) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          a_vld <= 1'b0;
          b_vld <= 1'b0;
          pos   <= '0;
          if (req_valid) tag_q <= address[ADDRESS_BITS-1:OFFSET_BITS];
        end
        ST_SCAN: begin
          a_vld  <= issue && !scan_hit;
          a_pos  <= pos;
          b_vld  <= a_vld && !scan_hit;
          b_pos  <= a_pos;
          b_slot <= rec_rdata;
          if (a_vld && a_pos == '0) lru <= rec_rdata;
          if (scan_hit) begin
            hit_q  <= 1'b1;
            slot_q <= b_slot;
            pos    <= b_pos + CNT_W'(1);
          end else if (scan_end) begin
            hit_q <= 1'b0;
            if (full) begin
              slot_q <= lru;
              pos    <= CNT_W'(1);
            end else begin
              slot_q <= count[SLOT_W-1:0];
            end
          end else if (issue) begin
            pos <= pos + CNT_W'(1);
          end
        end
        ST_SHIFT: begin
          a_vld <= issue;
          a_pos <= pos;
          if (issue) pos <= pos + CNT_W'(1);
        end
        ST_FINAL: begin
          if (!hit_q && !full) count <= count + CNT_W'(1);
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            hit       <= hit_q;
            tag       <= tag_q;
            slot      <= slot_q;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("fill count above capacity");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && !hit_q && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("fill did not advance the count");

  a_hit_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_hit) |-> (CNT_W'(b_slot) < count))
    else $error("hit on an unfilled slot");

  a_shift_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && a_vld) |-> (a_pos != '0 && a_pos < count))
    else $error("list move outside filled positions");

endmodule

/* tb/fully_associative_lru_cache_tb.sv */
// Self-checking testbench for fully_associative_lru_cache: a directed access table, then
// random accesses, each result checked against a behavioral LRU cache kept in the bench
// or against a typed table row. Depends only on the RTL of the block; both handshakes see random idle and stall cycles.
module fully_associative_lru_cache_tb;

  localparam int ENTRIES      = 128;
  localparam int OFFSET_BITS  = 2;
  localparam int ADDRESS_BITS = 32;
  localparam int TAG_W        = ADDRESS_BITS - OFFSET_BITS;
  localparam int SLOT_W       = $clog2(ENTRIES);
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 1300;
  localparam int POOL_SIZE    = 160;
  localparam int IDLE_PCT     = 32;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 40;
  localparam int MAX_REPORTS  = 200;

  typedef struct packed {
    logic              hit;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] addr;
    logic                    typed;
    logic                    e_hit;
    logic [TAG_W-1:0]        e_tag;
    logic [SLOT_W-1:0]       e_slot;
  } access_row_t;

  logic                    clk;
  logic                    rst;
  logic                    req_valid;
  logic                    req_stall;
  logic [ADDRESS_BITS-1:0] address;
  logic                    rsp_valid;
  logic                    rsp_stall;
  logic                    hit;
  logic [TAG_W-1:0]        tag;
  logic [SLOT_W-1:0]       slot;

  // behavioral cache state
  logic [TAG_W-1:0]  cache_tags  [ENTRIES];
  logic [SLOT_W-1:0] lru_list    [ENTRIES];
  int                used_count;

  lookup_t           pending_lookups [$];
  lookup_t           oldest_lookup;
  access_row_t       access_table [NUM_DIRECTED];
  logic [TAG_W-1:0]  tag_pool [POOL_SIZE];
  int                errors;
  bit                quiet;

  fully_associative_lru_cache #(
    .ENTRIES     (ENTRIES),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .address  (address),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .hit      (hit),
    .tag      (tag),
    .slot     (slot)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Look up one access, update recency and fill state, return the result.
  function automatic lookup_t cache_lookup(input logic [ADDRESS_BITS-1:0] a);
    lookup_t           r;
    int                pos;
    logic [SLOT_W-1:0] moved;
    r.hit  = 1'b0;
    r.tag  = a[ADDRESS_BITS-1:OFFSET_BITS];
    r.slot = '0;
    pos    = -1;
    for (int p = 0; p < used_count; p++)
      if (pos < 0 && cache_tags[lru_list[p]] == r.tag) pos = p;
    if (pos >= 0) begin
      r.hit  = 1'b1;
      r.slot = lru_list[pos];
    end else if (used_count < ENTRIES) begin
      r.slot = SLOT_W'(used_count);
      cache_tags[r.slot]   = r.tag;
      lru_list[used_count] = r.slot;
      used_count++;
    end else begin
      r.slot = lru_list[0];
      cache_tags[r.slot] = r.tag;
      pos = 0;
    end
    if (pos >= 0) begin
      moved = lru_list[pos];
      for (int i = pos; i < used_count - 1; i++) lru_list[i] = lru_list[i + 1];
      lru_list[used_count - 1] = moved;
    end
    return r;
  endfunction

  // Resident tags (LRU, MRU, any), a reuse pool larger than the cache, or full random
  // addresses; only full random addresses while the cache is empty.
  function automatic logic [ADDRESS_BITS-1:0] random_address();
    int               sel;
    logic [TAG_W-1:0] t;
    sel = $urandom_range(99);
    if (sel < 15 || used_count == 0) return $urandom;
    if (sel < 30) t = cache_tags[lru_list[0]];
    else if (sel < 40) t = cache_tags[lru_list[used_count - 1]];
    else if (sel < 60) t = cache_tags[lru_list[$urandom_range(used_count - 1)]];
    else t = tag_pool[$urandom_range(POOL_SIZE - 1)];
    return {t, OFFSET_BITS'($urandom)};
  endfunction

  initial begin
    logic [ADDRESS_BITS-1:0] a;
    lookup_t                 r;
    rst        = 1'b1;
    req_valid  = 1'b0;
    address    = '0;
    errors     = 0;
    quiet      = 1'b0;
    used_count = 0;
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = TAG_W'($urandom);

    //                 address        typed hit   tag            slot
    access_table[0]  = {32'h0000_0000, 1'b1, 1'b0, 30'h0000_0000, 7'd0};
    access_table[1]  = {32'hFFFF_FFFF, 1'b1, 1'b0, 30'h3FFF_FFFF, 7'd1};
    access_table[2]  = {32'h0000_0003, 1'b1, 1'b1, 30'h0000_0000, 7'd0}; // hit on LRU
    access_table[3]  = {32'hFFFF_FFFC, 1'b1, 1'b1, 30'h3FFF_FFFF, 7'd1}; // hit on LRU
    access_table[4]  = {32'hFFFF_FFFD, 1'b1, 1'b1, 30'h3FFF_FFFF, 7'd1}; // hit on MRU
    access_table[5]  = {32'h8000_0000, 1'b1, 1'b0, 30'h2000_0000, 7'd2};
    access_table[6]  = {32'h7FFF_FFFF, 1'b1, 1'b0, 30'h1FFF_FFFF, 7'd3};
    access_table[7]  = {32'h5555_5555, 1'b1, 1'b0, 30'h1555_5555, 7'd4};
    access_table[8]  = {32'hAAAA_AAAA, 1'b1, 1'b0, 30'h2AAA_AAAA, 7'd5};
    access_table[9]  = {32'h0000_0004, 1'b1, 1'b0, 30'h0000_0001, 7'd6};
    access_table[10] = {32'h0000_0002, 1'b1, 1'b1, 30'h0000_0000, 7'd0};
    access_table[11] = {32'h0000_0007, 1'b1, 1'b1, 30'h0000_0001, 7'd6};
    access_table[12] = {32'h1234_5678, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[13] = {32'h1234_567B, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[14] = {32'hDEAD_BEEF, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[15] = {32'h2AAA_AAA9, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[16] = {32'h8000_0003, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[17] = {32'h0000_0008, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[18] = {32'hFFFF_FFFE, 1'b0, 1'b0, 30'h0, 7'd0};
    access_table[19] = {32'h5555_5554, 1'b0, 1'b0, 30'h0, 7'd0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED + NUM_RANDOM; i++) begin
      quiet = (i >= 600 && i < 850);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
        req_valid <= 1'b0;
        address   <= $urandom;
        @(negedge clk);
      end
      if (i < NUM_DIRECTED) a = access_table[i].addr;
      else a = random_address();
      req_valid <= 1'b1;
      address   <= a;
      @(posedge clk);
      while (req_stall) @(posedge clk);
      r = cache_lookup(a);
      if (i < NUM_DIRECTED && access_table[i].typed)
        r = {access_table[i].e_hit, access_table[i].e_tag, access_table[i].e_slot};
      pending_lookups.push_back(r);
      @(negedge clk);
    end
    req_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    rsp_stall = 1'b1;
    forever begin
      @(negedge clk);
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_lookups.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected item: hit=%0b tag=%h slot=%0d", $time, hit, tag, slot);
        errors++;
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (hit !== oldest_lookup.hit) begin
          if (errors < MAX_REPORTS)
            $display("%0t: hit expected %0b actual %0b", $time, oldest_lookup.hit, hit);
          errors++;
        end
        if (tag !== oldest_lookup.tag) begin
          if (errors < MAX_REPORTS)
            $display("%0t: tag expected %h actual %h", $time, oldest_lookup.tag, tag);
          errors++;
        end
        if (slot !== oldest_lookup.slot) begin
          if (errors < MAX_REPORTS)
            $display("%0t: slot expected %0d actual %0d", $time, oldest_lookup.slot, slot);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* fully_associative_lru_cache.f */
hdl/flc_pkg.sv
hdl/flc_ram.sv
hdl/fully_associative_lru_cache.sv
tb/fully_associative_lru_cache_tb.sv
